FILE: hw/rtl/edit_distance_engine_defines.svh
// ----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shared property shorthands for the edit distance engine RTL.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define EDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define EDE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Sizes, word kinds, controller states and cell interface types.
// ----------------------------------------------------------------------------
package ede_pkg;

  localparam int MAX_LEN  = 32;
  // column values reach MAX_LEN + 1 before the min is taken
  localparam int CNT_W    = $clog2(MAX_LEN + 2);
  localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CHAR_W   = 8;
  localparam int DIST_W   = 6;
  localparam int DIST_MAX = (1 << DIST_W) - 1;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_CAND   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // candidate character travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic [CHAR_W-1:0] c;
    logic [CNT_W-1:0]  left;   // new value of the row above
    logic [CNT_W-1:0]  diag;   // old value of the row above
  } tok_t;

  typedef struct packed {
    logic init;   // reload column entry with its row number
    logic wr;     // store the word character
    logic en;     // row lies inside the stored word
  } cell_ctl_t;

endpackage

FILE: hw/rtl/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between a stored word and streamed candidates,
// computed by a row of cells that one candidate character walks down.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tuser kind, tdata char_code, tlast last
//  out_    | master    | tdata distance, tuser overflow
//
//  Clear and append words are handled without leaving the idle state.
//  A kept candidate word moves the engine to the run state while its character
//  moves one cell per cycle down the row of L active cells, L the stored word
//  length. With an empty word, or past MAX_LEN where the character is dropped, no run state is entered.
//  A last word adds the emit state and waits there while out_ is stalled.
//  Reset: empty word, column loaded with row numbers, no result pending.
// ----------------------------------------------------------------------------
`include "edit_distance_engine_defines.svh"

module edit_distance_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] distance, [7:6] zero
  output logic [0:0]  out_tuser   // [0] overflow
);

  localparam int N  = ede_pkg::MAX_LEN;
  localparam int CW = ede_pkg::CNT_W;

  ede_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   word_len_r, word_len_nxt;
  logic [CW-1:0]   cand_len_r, cand_len_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            word_ovf_r, word_ovf_nxt;
  logic            cand_ovf_r, cand_ovf_nxt;
  logic            pend_r, pend_nxt;
  ede_pkg::tok_t   tok_r, tok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ede_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            accept, out_free, emit_go, col_init, wr_go;
  logic            do_run, drop_cand;
  ede_pkg::kind_t  kind;
  logic [CW-1:0]   dist_full;
  logic [CW-1:0]   last_row;

  ede_pkg::tok_t      tok_chain [N+1];
  logic [CW-1:0]      val_vec   [N];
  ede_pkg::cell_ctl_t cell_ctl  [N];
  logic [N:0]         tok_vld;

  assign kind      = ede_pkg::kind_t'(in_tuser);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = (state_r == ede_pkg::ST_EMIT) && out_free;
  assign drop_cand = cand_len_r >= CW'(N);
  assign do_run    = !drop_cand && (word_len_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ede_pkg::ST_IDLE: begin
        if (accept && kind == ede_pkg::KIND_CAND) begin
          if (do_run) begin
            state_nxt = ede_pkg::ST_RUN;
          end else if (in_tlast) begin
            state_nxt = ede_pkg::ST_EMIT;
          end
        end
      end
      ede_pkg::ST_RUN: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = pend_r ? ede_pkg::ST_EMIT : ede_pkg::ST_IDLE;
        end
      end
      ede_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = ede_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ede_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready     = (state_r == ede_pkg::ST_IDLE);
    word_len_nxt  = word_len_r;
    cand_len_nxt  = cand_len_r;
    cnt_nxt       = cnt_r;
    word_ovf_nxt  = word_ovf_r;
    cand_ovf_nxt  = cand_ovf_r;
    pend_nxt      = pend_r;
    col_init      = 1'b0;
    wr_go         = 1'b0;
    tok_nxt.vld   = 1'b0;
    tok_nxt.c     = in_tdata;
    tok_nxt.diag  = cand_len_r;
    tok_nxt.left  = cand_len_r + CW'(1);
    out_valid_nxt = out_valid_r && !out_tready;
    out_ovf_nxt   = out_ovf_r;
    out_dist_nxt  = out_dist_r;
    last_row      = word_len_r - CW'(1);
    dist_full     = (word_len_r == '0) ? cand_len_r : val_vec[last_row[ede_pkg::IDX_W-1:0]];

    if (state_r == ede_pkg::ST_RUN) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    if (accept) begin
      case (kind)
        ede_pkg::KIND_CLEAR: begin
          word_len_nxt = '0;
          word_ovf_nxt = 1'b0;
          cand_len_nxt = '0;
          cand_ovf_nxt = 1'b0;
          col_init     = 1'b1;
        end
        ede_pkg::KIND_APPEND: begin
          if (word_len_r < CW'(N)) begin
            wr_go        = 1'b1;
            word_len_nxt = word_len_r + CW'(1);
          end else begin
            word_ovf_nxt = 1'b1;
          end
          cand_len_nxt = '0;
          cand_ovf_nxt = 1'b0;
          col_init     = 1'b1;
        end
        ede_pkg::KIND_CAND: begin
          pend_nxt = in_tlast;
          if (drop_cand) begin
            cand_ovf_nxt = 1'b1;
          end else begin
            cand_len_nxt = cand_len_r + CW'(1);
            tok_nxt.vld  = do_run;
            cnt_nxt      = word_len_r;
          end
        end
        default: ;
      endcase
    end

    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = word_ovf_r || cand_ovf_r;
      out_dist_nxt  = (dist_full > CW'(ede_pkg::DIST_MAX)) ?
                      ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : ede_pkg::DIST_W'(dist_full);
      cand_len_nxt  = '0;
      cand_ovf_nxt  = 1'b0;
      col_init      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ede_pkg::ST_IDLE;
      word_len_r  <= '0;
      cand_len_r  <= '0;
      cnt_r       <= '0;
      word_ovf_r  <= 1'b0;
      cand_ovf_r  <= 1'b0;
      pend_r      <= 1'b0;
      tok_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_len_r  <= word_len_nxt;
      cand_len_r  <= cand_len_nxt;
      cnt_r       <= cnt_nxt;
      word_ovf_r  <= word_ovf_nxt;
      cand_ovf_r  <= cand_ovf_nxt;
      pend_r      <= pend_nxt;
      tok_r.vld   <= tok_nxt.vld;
      out_valid_r <= out_valid_nxt;
    end
    tok_r.c    <= tok_nxt.c;
    tok_r.left <= tok_nxt.left;
    tok_r.diag <= tok_nxt.diag;
    out_dist_r <= out_dist_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign tok_chain[0] = tok_r;

  for (genvar j = 0; j < N; j++) begin : g_cell
    always_comb begin
      cell_ctl[j].init = col_init;
      cell_ctl[j].wr   = wr_go && (word_len_r == CW'(j));
      cell_ctl[j].en   = CW'(j) < word_len_r;
    end

    ede_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .row     (CW'(j + 1)),
      .ctl     (cell_ctl[j]),
      .wr_char (in_tdata),
      .tok_i   (tok_chain[j]),
      .tok_o   (tok_chain[j+1]),
      .val_o   (val_vec[j])
    );
  end

  for (genvar k = 0; k <= N; k++) begin : g_vld
    assign tok_vld[k] = tok_chain[k].vld;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - ede_pkg::DIST_W){1'b0}}, out_dist_r};
  assign out_tuser  = out_ovf_r;

  `EDE_ASSERT_IMP(a_single_word, 1'b1, $onehot0(tok_vld), "more than one word in the cell row")
  `EDE_ASSERT_IMP(a_len_range, 1'b1, (word_len_r <= CW'(N)) && (cand_len_r <= CW'(N)), "length past MAX_LEN")
  `EDE_ASSERT_IMP(a_run_word, state_r == ede_pkg::ST_RUN, word_len_r != '0, "run with an empty word")
  `EDE_ASSERT_NXT(a_run_start, accept && kind == ede_pkg::KIND_CAND && do_run, tok_r.vld && state_r == ede_pkg::ST_RUN, "candidate word not injected")

endmodule

FILE: hw/rtl/ede_cell.sv
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one word character and its column entry; updates the entry when the
// candidate token passes and hands the token on to the next row.
// ----------------------------------------------------------------------------
module ede_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ede_pkg::CNT_W-1:0] row,
  input  ede_pkg::cell_ctl_t        ctl,
  input  logic [ede_pkg::CHAR_W-1:0] wr_char,
  input  ede_pkg::tok_t             tok_i,
  output ede_pkg::tok_t             tok_o,
  output logic [ede_pkg::CNT_W-1:0] val_o
);

  logic [ede_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [ede_pkg::CNT_W-1:0]  val_r, val_nxt;
  ede_pkg::tok_t              tok_r, tok_nxt;
  logic [ede_pkg::CNT_W-1:0]  sub_cost, up_cost, left_cost, best;

  always_comb begin
    sub_cost  = tok_i.diag + ((ch_r != tok_i.c) ? ede_pkg::CNT_W'(1) : '0);
    up_cost   = val_r + ede_pkg::CNT_W'(1);
    left_cost = tok_i.left + ede_pkg::CNT_W'(1);
    best      = (sub_cost < up_cost) ? sub_cost : up_cost;
    if (left_cost < best) begin
      best = left_cost;
    end
  end

  always_comb begin
    ch_nxt  = ctl.wr ? wr_char : ch_r;
    val_nxt = val_r;
    if (ctl.init) begin
      val_nxt = row;
    end else if (tok_i.vld && ctl.en) begin
      val_nxt = best;
    end
    tok_nxt.vld  = tok_i.vld && ctl.en;
    tok_nxt.c    = tok_i.c;
    tok_nxt.left = best;
    tok_nxt.diag = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r     <= row;
      tok_r.vld <= 1'b0;
    end else begin
      val_r     <= val_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.c    <= tok_nxt.c;
    tok_r.left <= tok_nxt.left;
    tok_r.diag <= tok_nxt.diag;
    ch_r       <= ch_nxt;
  end

  assign tok_o = tok_r;
  assign val_o = val_r;

endmodule
